/* rtl/frd_pkg.sv */
// ----------------------------------------------------------------------------
// frd_pkg
// Shared types and constants for the frame reassembly deframer.
// ----------------------------------------------------------------------------
package frd_pkg;

  // field widths
  localparam int unsigned AddrW = 24;
  localparam int unsigned ByteW = 8;
  localparam int unsigned SeqW  = 8;

  // buffer capacity after reset
  localparam logic [AddrW-1:0] BufferSizeReset = 24'd307200;

  // packet type, taken from the low nibble of the header flag
  localparam logic [3:0] TYPE_START  = 4'h1;
  localparam logic [3:0] TYPE_MIDDLE = 4'h2;
  localparam logic [3:0] TYPE_END    = 4'h5;

  // what payload bytes do in the current packet
  localparam logic [1:0] MODE_IGNORE = 2'd0;
  localparam logic [1:0] MODE_COPY   = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  // item kind carried on tuser
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // one input item
  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] flag;
    logic [SeqW-1:0]  sequence_req;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic             write_valid;
    logic [AddrW-1:0] write_address;
    logic [ByteW-1:0] write_data;
    logic             frame_done;
    logic [AddrW-1:0] frame_length;
  } result_t;

endpackage

/* rtl/frd_engine.sv */
// ----------------------------------------------------------------------------
// frd_engine
// Sequence check, frame state and write head; works out one item per cycle while step_en is high.
// ----------------------------------------------------------------------------
module frd_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  frd_pkg::item_t                item,
  input  logic [frd_pkg::AddrW-1:0]     buffer_size,
  output frd_pkg::result_t              res,
  output logic                          res_present
);

  logic [frd_pkg::SeqW-1:0]  last_seq_r, last_seq_nxt;
  logic                      dropped_r, dropped_nxt;
  logic [frd_pkg::AddrW-1:0] head_r, head_nxt;
  logic [1:0]                mode_r, mode_nxt;
  logic                      in_order;
  logic [3:0]                pkt_type;

  assign pkt_type = item.flag[3:0];
  assign in_order = (item.sequence_req == last_seq_r + frd_pkg::SeqW'(1));

  // next state and result for the item at the input
  always_comb begin
    last_seq_nxt = last_seq_r;
    dropped_nxt  = dropped_r;
    head_nxt     = head_r;
    mode_nxt     = mode_r;
    res          = '0;
    if (item.kind == frd_pkg::KIND_HEADER) begin
      last_seq_nxt = item.sequence_req;
      case (pkt_type)
        frd_pkg::TYPE_START: begin
          dropped_nxt = 1'b0;
          head_nxt    = '0;
          mode_nxt    = frd_pkg::MODE_COPY;
        end
        frd_pkg::TYPE_MIDDLE: begin
          if (in_order) begin
            mode_nxt = frd_pkg::MODE_COPY;
          end else begin
            dropped_nxt = 1'b1;
            mode_nxt    = frd_pkg::MODE_IGNORE;
          end
        end
        frd_pkg::TYPE_END: begin
          mode_nxt = frd_pkg::MODE_END;
        end
        default: begin
          mode_nxt = frd_pkg::MODE_IGNORE;
        end
      endcase
    end else begin
      if (mode_r == frd_pkg::MODE_COPY || mode_r == frd_pkg::MODE_END) begin
        // writes stop at the buffer size
        if (head_r < buffer_size) begin
          res.write_valid   = 1'b1;
          res.write_address = head_r;
          res.write_data    = item.data_byte;
          head_nxt          = head_r + frd_pkg::AddrW'(1);
        end
        // end of an undropped frame
        if (mode_r == frd_pkg::MODE_END && item.last_byte && !dropped_r) begin
          res.frame_done   = 1'b1;
          res.frame_length = head_nxt;
          dropped_nxt      = 1'b1;
        end
      end
      if (item.last_byte) begin
        mode_nxt = frd_pkg::MODE_IGNORE;
      end
    end
  end

  assign res_present = res.write_valid | res.frame_done;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r <= '0;
      dropped_r  <= 1'b1;
      head_r     <= '0;
      mode_r     <= frd_pkg::MODE_IGNORE;
    end else if (step_en) begin
      last_seq_r <= last_seq_nxt;
      dropped_r  <= dropped_nxt;
      head_r     <= head_nxt;
      mode_r     <= mode_nxt;
    end
  end

endmodule

/* rtl/frame_reassembly_deframer.sv */
// ----------------------------------------------------------------------------
// frame_reassembly_deframer
// Rebuilds camera frames from sequenced packets and emits buffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per item; tuser is the kind (header or payload byte),
//           tdata holds flag, sequence number and payload byte, tlast marks
//           the final payload byte of a packet.
//   out_* : one beat per buffer write or finished frame; tuser holds the
//           write-valid and frame-done flags, tdata the write address, the
//           byte and the frame length.
//   cfg_* : writes the buffer size; always ready, written only while idle; the user
//           must keep to that, as the block does not enforce it.
// Throughput: one input beat per cycle unless the output stalls; headers and discarded
//   bytes give no output beat. The single output register sets the rate and is reloaded
//   in the same cycle it is taken. A result is offered in the cycle after its beat.
// Reset: sequence 0, frame dropped, write head 0, payload ignored, buffer
//   size 307200, output empty.
// Stall: while out_tready is low and a result waits, in_tready is low and
//   all state holds.
// ----------------------------------------------------------------------------
module frame_reassembly_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // flag, sequence_req, data_byte
  input  logic                       in_tuser,   // kind
  input  logic                       in_tlast,   // last_byte
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [55:0]                out_tdata,  // write_address, write_data, frame_length
  output logic [1:0]                 out_tuser,  // write_valid, frame_done
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [frd_pkg::AddrW-1:0]  cfg_data
);

  logic [frd_pkg::AddrW-1:0] buffer_size_r;
  frd_pkg::item_t            item;
  frd_pkg::result_t          res;
  frd_pkg::result_t          out_r;
  logic                      res_present;
  logic                      out_valid_r;
  logic                      in_accept;

  assign cfg_ready = 1'b1;

  // buffer size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= frd_pkg::BufferSizeReset;
    end else if (cfg_valid) begin
      buffer_size_r <= cfg_data;
    end
  end

  // unpack the input beat
  assign item.kind         = in_tuser;
  assign item.flag         = in_tdata[7:0];
  assign item.sequence_req = in_tdata[15:8];
  assign item.data_byte    = in_tdata[23:16];
  assign item.last_byte    = in_tlast;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  frd_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_accept),
    .item        (item),
    .buffer_size (buffer_size_r),
    .res         (res),
    .res_present (res_present)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_accept && res_present;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_present) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_r.frame_done, out_r.write_valid};
  assign out_tdata  = {out_r.frame_length, out_r.write_data, out_r.write_address};

endmodule

/* rtl/frd_checker.sv */
// ----------------------------------------------------------------------------
// frd_checker
// Port-level checks on the deframer result stream.
// ----------------------------------------------------------------------------
module frd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // every result carries a write or a finished frame
  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'b00))
    else $error("empty result beat");

  // no write means zero address and data
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[31:0] == 32'd0))
    else $error("write fields set without a write");

  // no finished frame means zero length
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> (out_tdata[55:32] == 24'd0))
    else $error("frame length set without frame done");

  // output empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind frame_reassembly_deframer frd_checker u_frd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame reassembly deframer: a queue-fed stream
// driver, a checking monitor and a behavioral tracker of frame state that
// predicts every buffer write and finished frame across several buffer sizes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned LongHoldAfter = 300;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // dut ports
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [23:0]               in_tdata = '0;    // flag, sequence_req, data_byte
  logic                      in_tuser = 1'b0;  // kind
  logic                      in_tlast = 1'b0;  // last_byte
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [55:0]               out_tdata;        // write_address, write_data, frame_length
  logic [1:0]                out_tuser;        // write_valid, frame_done
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [frd_pkg::AddrW-1:0] cfg_data = '0;

  // stimulus and expectations
  frd_pkg::item_t   packet_items[$];
  frd_pkg::result_t pending_writes[$];
  frd_pkg::item_t   offered;
  int unsigned items_queued = 0;

  // tracked block state
  logic [frd_pkg::SeqW-1:0]  track_seq;
  logic                      track_dropped;
  logic [frd_pkg::AddrW-1:0] track_head;
  logic [1:0]                track_mode;
  logic [frd_pkg::AddrW-1:0] track_size;

  // generator's own view of the last header sequence
  logic [frd_pkg::SeqW-1:0] gen_seq = '0;

  // sender and receiver pacing
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_age = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // bookkeeping
  int unsigned error_count = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned frames_done = 0;
  int unsigned input_stalls = 0;
  int unsigned size_writes = 0;
  int unsigned idle_cycles = 0;

  frame_reassembly_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // tracker: advance frame state for one accepted item, queue any result
  task automatic reassemble_item(input frd_pkg::item_t it);
    frd_pkg::result_t r;
    logic [frd_pkg::SeqW-1:0] next_seq;
    logic in_order;
    r = '0;
    if (it.kind == frd_pkg::KIND_HEADER) begin
      next_seq = track_seq + 8'd1;
      in_order = (it.sequence_req == next_seq);
      track_seq = it.sequence_req;
      case (it.flag[3:0])
        frd_pkg::TYPE_START: begin
          track_dropped = 1'b0;
          track_head = '0;
          track_mode = frd_pkg::MODE_COPY;
        end
        frd_pkg::TYPE_MIDDLE: begin
          if (in_order) begin
            track_mode = frd_pkg::MODE_COPY;
          end else begin
            track_dropped = 1'b1;
            track_mode = frd_pkg::MODE_IGNORE;
          end
        end
        frd_pkg::TYPE_END: track_mode = frd_pkg::MODE_END;
        default: track_mode = frd_pkg::MODE_IGNORE;
      endcase
    end else begin
      if (track_mode == frd_pkg::MODE_COPY || track_mode == frd_pkg::MODE_END) begin
        // bytes past the buffer end are dropped and the head stays put
        if (track_head < track_size) begin
          r.write_valid = 1'b1;
          r.write_address = track_head;
          r.write_data = it.data_byte;
          track_head = track_head + frd_pkg::AddrW'(1);
        end
        if (track_mode == frd_pkg::MODE_END && it.last_byte && !track_dropped) begin
          r.frame_done = 1'b1;
          r.frame_length = track_head;
          track_dropped = 1'b1;
        end
      end
      if (it.last_byte) track_mode = frd_pkg::MODE_IGNORE;
      if (r.write_valid || r.frame_done) pending_writes.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
               $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // driver: bursts with random gaps, prediction on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        reassemble_item(offered);
        beats_in++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
        end
      end
      if (in_tvalid && !in_tready) input_stalls++;
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (packet_items.size() > 0) begin
          offered = packet_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {offered.data_byte, offered.sequence_req, offered.flag};
          in_tuser <= offered.kind;
          in_tlast <= offered.last_byte;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, pace out_tready
  always @(posedge clk) begin
    frd_pkg::result_t got;
    frd_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.write_valid = out_tuser[0];
      got.frame_done = out_tuser[1];
      got.write_address = out_tdata[23:0];
      got.write_data = out_tdata[31:24];
      got.frame_length = out_tdata[55:32];
      beats_out++;
      if (got.frame_done) frames_done++;
      if (pending_writes.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual 0x%0h",
                 $time, got);
        error_count++;
      end else begin
        want = pending_writes.pop_front();
        check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
        check_field("write_address", 32'(want.write_address),
                    32'(got.write_address));
        check_field("write_data", 32'(want.write_data), 32'(got.write_data));
        check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        check_field("frame_length", 32'(want.frame_length),
                    32'(got.frame_length));
      end
    end
    // stall pattern, reloaded now and then; one long hold to back up the input
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    pattern_age++;
    if (pattern_age == 128) begin
      pattern_age = 0;
      ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && beats_in >= LongHoldAfter) begin
      hold_done = 1'b1;
      hold_left = LongHoldCycles;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ready_pattern[0];
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // stimulus helpers
  task automatic add_header(input logic [7:0] flag,
                            input logic [frd_pkg::SeqW-1:0] seq);
    frd_pkg::item_t it;
    it.kind = frd_pkg::KIND_HEADER;
    it.flag = flag;
    it.sequence_req = seq;
    it.data_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    gen_seq = seq;
    packet_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_byte(input logic [7:0] data, input logic last);
    frd_pkg::item_t it;
    it.kind = frd_pkg::KIND_PAYLOAD;
    it.flag = 8'($urandom);
    it.sequence_req = 8'($urandom);
    it.data_byte = data;
    it.last_byte = last;
    packet_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_bytes(input int unsigned n, input logic terminate);
    for (int unsigned i = 0; i < n; i++) begin
      add_byte(8'($urandom), terminate && (i == n - 1));
    end
  endtask

  function automatic logic [7:0] rand_flag(input logic [3:0] ptype);
    logic [3:0] hi;
    hi = 4'($urandom);
    return {hi, ptype};
  endfunction

  function automatic int unsigned pick_len(input int unsigned max_len);
    if ($urandom_range(0, 19) == 0) return $urandom_range(max_len, 4 * max_len);
    return $urandom_range(1, max_len);
  endfunction

  // random packet traffic, mostly whole frames with in-order sequences
  task automatic gen_traffic(input int unsigned n_items, input int unsigned max_len);
    int unsigned first;
    int unsigned pick;
    int unsigned mids;
    logic [3:0] ptype;
    logic [frd_pkg::SeqW-1:0] bad_seq;
    first = items_queued;
    while (items_queued - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        add_header(rand_flag(frd_pkg::TYPE_START), gen_seq + 8'd1);
        add_bytes(pick_len(max_len), 1'b1);
        mids = $urandom_range(0, 3);
        repeat (mids) begin
          add_header(rand_flag(frd_pkg::TYPE_MIDDLE), gen_seq + 8'd1);
          add_bytes(pick_len(max_len), 1'b1);
        end
        add_header(rand_flag(frd_pkg::TYPE_END), gen_seq + 8'd1);
        add_bytes(pick_len(max_len), 1'b1);
      end else if (pick < 80) begin
        // middle packet out of order
        bad_seq = gen_seq + 8'd2 + 8'($urandom_range(0, 253));
        add_header(rand_flag(frd_pkg::TYPE_MIDDLE), bad_seq);
        add_bytes(pick_len(max_len), 1'b1);
      end else if (pick < 85) begin
        // packet of an ignored type
        do ptype = 4'($urandom_range(0, 15));
        while (ptype == frd_pkg::TYPE_START || ptype == frd_pkg::TYPE_MIDDLE ||
               ptype == frd_pkg::TYPE_END);
        add_header({4'($urandom), ptype}, 8'($urandom));
        add_bytes(pick_len(max_len), 1'b1);
      end else if (pick < 90) begin
        // stray bytes between packets
        add_bytes($urandom_range(1, 3), 1'($urandom));
      end else if (pick < 95) begin
        // packet cut short by the next header
        case ($urandom_range(0, 2))
          0: ptype = frd_pkg::TYPE_START;
          1: ptype = frd_pkg::TYPE_MIDDLE;
          default: ptype = frd_pkg::TYPE_END;
        endcase
        add_header(rand_flag(ptype), gen_seq + 8'd1);
        add_bytes(pick_len(max_len), 1'b0);
      end else begin
        // lone end packet, frame may or may not be live
        add_header(rand_flag(frd_pkg::TYPE_END), gen_seq + 8'd1);
        add_bytes(pick_len(max_len), 1'b1);
      end
    end
  endtask

  // wait for the block to go quiet
  task automatic drain();
    while (packet_items.size() != 0 || in_tvalid || pending_writes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [frd_pkg::AddrW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    track_size = value;
    size_writes++;
    @(negedge clk);
  endtask

  // main sequence
  initial begin
    track_seq = '0;
    track_dropped = 1'b1;
    track_head = '0;
    track_mode = frd_pkg::MODE_IGNORE;
    track_size = frd_pkg::BufferSizeReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: stray byte, start/middle/end, dropped frames, ignore type,
    // sequence wrap and headers inside a packet
    add_byte(8'hFF, 1'b1);
    add_header(8'hF1, 8'h01);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hAA, 1'b0);
    add_header(8'h02, 8'h02);
    add_byte(8'h55, 1'b1);
    add_header(8'h05, 8'h03);
    add_byte(8'h0F, 1'b0);
    add_byte(8'hF0, 1'b1);
    add_header(8'h02, 8'h04);
    add_byte(8'h11, 1'b1);
    add_header(8'hA5, 8'h05);
    add_byte(8'h22, 1'b1);
    add_header(8'h52, 8'h09);
    add_byte(8'h33, 1'b1);
    add_header(8'hFF, 8'h0A);
    add_byte(8'h44, 1'b1);
    add_header(8'hF1, 8'hFF);
    add_header(8'h02, 8'h00);
    add_byte(8'h66, 1'b0);
    add_header(8'h05, 8'h01);
    add_byte(8'h77, 1'b1);
    drain();

    // one-byte buffer: frame ends with the buffer already full
    write_buffer_size(24'd1);
    add_header(8'h01, gen_seq + 8'd1);
    add_bytes(3, 1'b0);
    add_header(8'h05, gen_seq + 8'd1);
    add_byte(8'h5A, 1'b1);
    gen_traffic(150, 4);
    drain();

    write_buffer_size(24'hFFFFFF);
    gen_traffic(300, 12);
    drain();

    write_buffer_size(frd_pkg::AddrW'($urandom_range(4, 40)));
    gen_traffic(300, 10);
    drain();

    // zero capacity discards every byte
    write_buffer_size(24'd0);
    gen_traffic(40, 4);
    drain();

    write_buffer_size(frd_pkg::BufferSizeReset);
    gen_traffic(130, 16);
    drain();

    $display("covered %0d input beats and %0d result beats, %0d finished frames,",
             beats_in, beats_out, frames_done);
    $display("%0d buffer sizes, input held off for %0d cycles by output back-pressure",
             size_writes, input_stalls);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
